// ----- rtl/core/kcc_pkg.sv -----
// Shared types and constants for the key click classifier.
`timescale 1ns / 1ps

package kcc_pkg;

  // Default configuration of the top level
  localparam int NUM_KEYS_DEF = 8;
  localparam int PIN_BITS_DEF = 6;

  // Fixed field widths
  localparam int PIN_W    = 6;
  localparam int SLOT_W   = 3;
  localparam int TIME_W   = 32;
  localparam int MS_W     = 16;
  localparam int COUNT_W  = 4;
  localparam int MAP_W    = 48;
  localparam int APB_DW   = 64;
  localparam int APB_AW   = 5;

  // Register reset values
  localparam logic [MS_W-1:0]    DEBOUNCE_RST  = 16'd50;
  localparam logic [MS_W-1:0]    DOUBLE_RST    = 16'd400;
  localparam logic [COUNT_W-1:0] KEY_COUNT_RST = 4'd0;
  localparam logic [MAP_W-1:0]   PIN_MAP_RST   = 48'd0;

  // Register index, taken from paddr[4:3]
  typedef enum logic [1:0] {
    REG_DEBOUNCE  = 2'd0,
    REG_DOUBLE    = 2'd1,
    REG_KEY_COUNT = 2'd2,
    REG_PIN_MAP   = 2'd3
  } kcc_reg_e;

  typedef enum logic {
    CLICK_SINGLE = 1'b0,
    CLICK_DOUBLE = 1'b1
  } kcc_click_e;

  // Per-slot state held in the slot memory
  typedef struct packed {
    logic              pressed;
    logic              pending;
    logic [TIME_W-1:0] press_time;
    logic [TIME_W-1:0] release_time;
  } kcc_entry_t;

endpackage

// ----- rtl/core/key_click_classifier.sv -----
// Key click classifier: slot lookup, slot memory update and click reporting.
`timescale 1ns / 1ps

// Takes one pin edge event per cycle. In the lookup stage the event's pin is
// compared against all slots in use at once and the first matching slot's
// state is read from the slot memory into its registered read data; events for
// unknown pins are taken and dropped there. In the update stage the state is
// updated and written back, and a single or double click, if any, is loaded
// into the output register, which holds it on the click outputs.
// An event for the same slot in the very next cycle gets the freshly written
// state by forwarding. Throughput is one event per cycle; the input stalls
// only while a click waits in the output register and the consumer stalls.
// Slot state starts cleared after reset; there is no clearing pass. Writing
// the pin map or key count leaves slot state as it is.
module key_click_classifier #(
  parameter int NUM_KEYS = kcc_pkg::NUM_KEYS_DEF,
  parameter int PIN_BITS = kcc_pkg::PIN_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // event input
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [kcc_pkg::PIN_W-1:0]   pin_i,
  input  logic                        level_i,
  input  logic [kcc_pkg::TIME_W-1:0]  now_ms_i,
  // click output
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [kcc_pkg::SLOT_W-1:0]  key_slot_o,
  output logic [kcc_pkg::PIN_W-1:0]   key_pin_o,
  output logic                        click_kind_o,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [kcc_pkg::APB_AW-1:0]  paddr,
  input  logic [kcc_pkg::APB_DW-1:0]  pwdata,
  output logic [kcc_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  localparam int SlotW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int CmpW  = (PIN_BITS > kcc_pkg::PIN_W) ? PIN_BITS : kcc_pkg::PIN_W;
  localparam int MapW  = (NUM_KEYS * PIN_BITS > kcc_pkg::MAP_W) ?
                         NUM_KEYS * PIN_BITS : kcc_pkg::MAP_W;
  localparam int EntW  = $bits(kcc_pkg::kcc_entry_t);

  // ---------------------------------------------------------------- config
  logic [kcc_pkg::MS_W-1:0]    debounce_q;
  logic [kcc_pkg::MS_W-1:0]    double_q;
  logic [kcc_pkg::COUNT_W-1:0] key_count_q;
  logic [kcc_pkg::MAP_W-1:0]   pin_map_q;
  kcc_pkg::kcc_reg_e           reg_sel;
  logic                        cfg_wr;

  assign reg_sel = kcc_pkg::kcc_reg_e'(paddr[4:3]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q  <= kcc_pkg::DEBOUNCE_RST;
      double_q    <= kcc_pkg::DOUBLE_RST;
      key_count_q <= kcc_pkg::KEY_COUNT_RST;
      pin_map_q   <= kcc_pkg::PIN_MAP_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        kcc_pkg::REG_DEBOUNCE:  debounce_q  <= pwdata[kcc_pkg::MS_W-1:0];
        kcc_pkg::REG_DOUBLE:    double_q    <= pwdata[kcc_pkg::MS_W-1:0];
        kcc_pkg::REG_KEY_COUNT: key_count_q <= pwdata[kcc_pkg::COUNT_W-1:0];
        kcc_pkg::REG_PIN_MAP:   pin_map_q   <= pwdata[kcc_pkg::MAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      kcc_pkg::REG_DEBOUNCE:  prdata = kcc_pkg::APB_DW'(debounce_q);
      kcc_pkg::REG_DOUBLE:    prdata = kcc_pkg::APB_DW'(double_q);
      kcc_pkg::REG_KEY_COUNT: prdata = kcc_pkg::APB_DW'(key_count_q);
      kcc_pkg::REG_PIN_MAP:   prdata = kcc_pkg::APB_DW'(pin_map_q);
      default:                prdata = '0;
    endcase
  end

  // ------------------------------------------------------- stage A: lookup
  logic [MapW-1:0]             pin_map_ext;
  logic [kcc_pkg::COUNT_W-1:0] used;
  logic [NUM_KEYS-1:0]         hit;
  logic                        hit_any;
  logic [SlotW-1:0]            hit_slot;
  logic                        in_acc;

  assign pin_map_ext = MapW'(pin_map_q);
  assign used = (key_count_q > kcc_pkg::COUNT_W'(NUM_KEYS)) ?
                kcc_pkg::COUNT_W'(NUM_KEYS) : key_count_q;

  always_comb begin
    for (int s = 0; s < NUM_KEYS; s++) begin
      hit[s] = (kcc_pkg::COUNT_W'(s) < used) &&
               (CmpW'(pin_map_ext[s*PIN_BITS +: PIN_BITS]) == CmpW'(pin_i));
    end
  end

  // lowest matching slot wins
  always_comb begin
    hit_slot = '0;
    for (int s = NUM_KEYS - 1; s >= 0; s--) begin
      if (hit[s]) begin
        hit_slot = SlotW'(s);
      end
    end
  end

  assign hit_any = |hit;
  assign in_acc  = in_valid_i && !in_stall_o;

  // ------------------------------------------------------ stage B: update
  logic                       s1_valid_q;
  logic [SlotW-1:0]           s1_slot_q;
  logic                       s1_level_q;
  logic [kcc_pkg::TIME_W-1:0] s1_now_q;
  logic                       byp_q;
  kcc_pkg::kcc_entry_t        byp_data_q;
  logic [NUM_KEYS-1:0]        valid_q;

  logic [EntW-1:0]            ram_rdata;
  kcc_pkg::kcc_entry_t        ent;
  kcc_pkg::kcc_entry_t        ent_new;
  logic [kcc_pkg::TIME_W-1:0] held;
  logic [kcc_pkg::TIME_W-1:0] gap;
  logic                       just_set;
  logic                       res;
  kcc_pkg::kcc_click_e        res_kind;
  logic                       out_free;
  logic                       b_fire;
  logic                       ram_we;

  // forwarded write from the previous transaction beats memory read data
  assign ent = byp_q ? byp_data_q :
               (valid_q[s1_slot_q] ? kcc_pkg::kcc_entry_t'(ram_rdata) : '0);

  assign held = s1_now_q - ent.press_time;
  assign gap  = s1_now_q - ent.release_time;

  always_comb begin
    ent_new  = ent;
    just_set = 1'b0;
    res      = 1'b0;
    res_kind = kcc_pkg::CLICK_SINGLE;
    if (!s1_level_q && !ent.pressed) begin
      ent_new.press_time = s1_now_q;
      ent_new.pressed    = 1'b1;
    end else if (s1_level_q && ent.pressed) begin
      ent_new.pressed = 1'b0;
      if (held >= kcc_pkg::TIME_W'(debounce_q)) begin
        if (!ent.pending) begin
          ent_new.pending      = 1'b1;
          ent_new.release_time = s1_now_q;
          just_set             = 1'b1;
        end else if (gap <= kcc_pkg::TIME_W'(double_q)) begin
          ent_new.pending = 1'b0;
          res             = 1'b1;
          res_kind        = kcc_pkg::CLICK_DOUBLE;
        end
      end
    end
    // single-click timeout; a click pending from this very release is excluded by just_set
    if (!res && !just_set && ent_new.pending && gap > kcc_pkg::TIME_W'(double_q)) begin
      ent_new.pending = 1'b0;
      res             = 1'b1;
      res_kind        = kcc_pkg::CLICK_SINGLE;
    end
  end

  logic out_valid_q;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign b_fire     = s1_valid_q && (!res || out_free);
  assign ram_we     = b_fire;
  assign in_stall_o = s1_valid_q && !b_fire;

  kcc_ram #(
    .WIDTH (EntW),
    .DEPTH (NUM_KEYS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_slot_q),
    .wdata_i (EntW'(ent_new)),
    .re_i    (in_acc),
    .raddr_i (hit_slot),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      byp_q      <= 1'b0;
      valid_q    <= '0;
    end else begin
      if (ram_we) begin
        valid_q[s1_slot_q] <= 1'b1;
      end
      if (in_acc) begin
        s1_valid_q <= hit_any;
        byp_q      <= hit_any && ram_we && (s1_slot_q == hit_slot);
      end else if (b_fire) begin
        s1_valid_q <= 1'b0;
        byp_q      <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_slot_q  <= hit_slot;
      s1_level_q <= level_i;
      s1_now_q   <= now_ms_i;
      byp_data_q <= ent_new;
    end
  end

  // ---------------------------------------------------------- output reg
  logic [CmpW-1:0]              click_pin;
  logic [kcc_pkg::SLOT_W-1:0]   out_slot_q;
  logic [kcc_pkg::PIN_W-1:0]    out_pin_q;
  kcc_pkg::kcc_click_e          out_kind_q;
  logic                         out_load;

  assign click_pin = CmpW'(pin_map_ext[s1_slot_q*PIN_BITS +: PIN_BITS]);
  assign out_load  = b_fire && res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_slot_q <= kcc_pkg::SLOT_W'(s1_slot_q);
      out_pin_q  <= click_pin[kcc_pkg::PIN_W-1:0];
      out_kind_q <= res_kind;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign key_slot_o   = out_slot_q;
  assign key_pin_o    = out_pin_q;
  assign click_kind_o = logic'(out_kind_q);

`ifndef SYNTH
  // a double click only ever comes from a release edge
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && res_kind == kcc_pkg::CLICK_DOUBLE) |-> s1_level_q)
    else $error("double click reported on a press edge");

  // a reported click always leaves the slot with nothing pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !ent_new.pending)
    else $error("click reported but slot still pending");

  // forwarding only flagged for a transaction held in the update stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    byp_q |-> s1_valid_q)
    else $error("forwarding flag without a transaction in the update stage");

  // the input side stalls only behind a blocked click
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without output back-pressure");
`endif

endmodule

// ----- rtl/core/kcc_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module kcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- tb/key_click_classifier_chk.sv -----
// Click checker: tracks key slot state, predicts clicks and compares them.
`timescale 1ns / 1ps

module key_click_classifier_chk (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic [kcc_pkg::PIN_W-1:0]   pin_i,
  input  logic                        level_i,
  input  logic [kcc_pkg::TIME_W-1:0]  now_ms_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic [kcc_pkg::SLOT_W-1:0]  key_slot_i,
  input  logic [kcc_pkg::PIN_W-1:0]   key_pin_i,
  input  logic                        click_kind_i,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic                        pready_i,
  input  logic [kcc_pkg::APB_AW-1:0]  paddr_i,
  input  logic [kcc_pkg::APB_DW-1:0]  pwdata_i,
  output int                          fail_count_o,
  output int                          pending_o
);
  import kcc_pkg::*;

  localparam int NK = NUM_KEYS_DEF;
  localparam int PB = PIN_BITS_DEF;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [PIN_W-1:0]  pin;
    kcc_click_e        kind;
  } click_t;

  logic [MS_W-1:0]    debounce_q;
  logic [MS_W-1:0]    double_q;
  logic [COUNT_W-1:0] key_count_q;
  logic [MAP_W-1:0]   pin_map_q;
  kcc_entry_t         slot_q [NK];
  click_t             click_q [$];

  // Updates the matching slot and returns 1 when the event yields a click
  function automatic bit classify_event(input logic [PIN_W-1:0] pin, input logic level,
                                        input logic [TIME_W-1:0] now, output click_t click);
    int                used;
    int                hit;
    bit                fired;
    kcc_entry_t        e;
    logic [TIME_W-1:0] held;
    logic [TIME_W-1:0] since_rel;
    used  = (int'(key_count_q) > NK) ? NK : int'(key_count_q);
    hit   = -1;
    fired = 1'b0;
    click = '0;
    // first matching slot wins
    for (int s = used - 1; s >= 0; s--) begin
      if (pin_map_q[s*PB +: PB] == pin) hit = s;
    end
    if (hit < 0) return 1'b0;
    e          = slot_q[hit];
    click.slot = SLOT_W'(hit);
    click.pin  = PIN_W'(pin_map_q[hit*PB +: PB]);
    if (!level && !e.pressed) begin
      e.press_time = now;
      e.pressed    = 1'b1;
    end else if (level && e.pressed) begin
      held      = now - e.press_time;
      e.pressed = 1'b0;
      if (held >= TIME_W'(debounce_q)) begin
        since_rel = now - e.release_time;
        if (!e.pending) begin
          e.pending      = 1'b1;
          e.release_time = now;
        end else if (since_rel <= TIME_W'(double_q)) begin
          e.pending  = 1'b0;
          click.kind = CLICK_DOUBLE;
          fired      = 1'b1;
        end
      end
    end
    // a late second click falls through here and reports the pending single
    since_rel = now - e.release_time;
    if (!fired && e.pending && since_rel > TIME_W'(double_q)) begin
      e.pending  = 1'b0;
      click.kind = CLICK_SINGLE;
      fired      = 1'b1;
    end
    slot_q[hit] = e;
    return fired;
  endfunction

  // Sampled on the falling edge: what is seen here is what the next rising edge takes
  always @(negedge clk_i or negedge rst_ni) begin
    click_t got;
    click_t want;
    click_t click;
    if (!rst_ni) begin
      debounce_q  = DEBOUNCE_RST;
      double_q    = DOUBLE_RST;
      key_count_q = KEY_COUNT_RST;
      pin_map_q   = PIN_MAP_RST;
      foreach (slot_q[k]) slot_q[k] = '0;
      click_q.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (kcc_reg_e'(paddr_i[4:3]))
          REG_DEBOUNCE:  debounce_q  = pwdata_i[MS_W-1:0];
          REG_DOUBLE:    double_q    = pwdata_i[MS_W-1:0];
          REG_KEY_COUNT: key_count_q = pwdata_i[COUNT_W-1:0];
          REG_PIN_MAP:   pin_map_q   = pwdata_i[MAP_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        got.slot = key_slot_i;
        got.pin  = key_pin_i;
        got.kind = kcc_click_e'(click_kind_i);
        if (click_q.size() == 0) begin
          $error("unexpected click: slot %0d pin %0d kind %0d", got.slot, got.pin, got.kind);
          fail_count_o++;
        end else begin
          want = click_q.pop_front();
          if (got.slot !== want.slot) begin
            $error("key_slot: expected %0d, got %0d", want.slot, got.slot);
            fail_count_o++;
          end
          if (got.pin !== want.pin) begin
            $error("key_pin: expected %0d, got %0d", want.pin, got.pin);
            fail_count_o++;
          end
          if (got.kind !== want.kind) begin
            $error("click_kind: expected %0d, got %0d", want.kind, got.kind);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (classify_event(pin_i, level_i, now_ms_i, click)) click_q.push_back(click);
      end
    end
    pending_o = click_q.size();
  end

endmodule

// ----- tb/key_click_classifier_tb.sv -----
// Testbench top for the key click classifier: stimulus, stalls and verdict.
`timescale 1ns / 1ps

module key_click_classifier_tb;
  import kcc_pkg::*;

  localparam int N_PHASES     = 5;
  localparam int PHASE_ITEMS  = 130;
  localparam int WAIT_MAX     = 16;
  localparam int LONG_HOLD    = 400;
  localparam int IDLE_LIMIT   = 3000;
  localparam int DRAIN_CYCLES = 4;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               ev_valid  = 1'b0;
  logic               in_stall;
  logic [PIN_W-1:0]   ev_pin    = '0;
  logic               ev_level  = 1'b1;
  logic [TIME_W-1:0]  ev_now    = '0;
  logic               res_valid;
  logic               res_stall = 1'b0;
  logic [SLOT_W-1:0]  res_slot;
  logic [PIN_W-1:0]   res_pin;
  logic               res_kind;
  logic               psel      = 1'b0;
  logic               penable   = 1'b0;
  logic               pwrite    = 1'b0;
  logic [APB_AW-1:0]  paddr     = '0;
  logic [APB_DW-1:0]  pwdata    = '0;
  logic [APB_DW-1:0]  prdata;
  logic               pready;

  int                 fail_count;
  int                 pending;
  int                 idle_cycles = 0;

  // stimulus-side view of the configuration and of the keys
  int                 cur_debounce;
  int                 cur_double;
  int                 cur_count;
  logic [MAP_W-1:0]   cur_map;
  bit                 pin_down [64];
  logic [TIME_W-1:0]  t_ms;
  int                 tx_calm   = 0;
  int                 rx_calm   = 0;
  bit                 long_hold = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  key_click_classifier u_top (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (ev_valid),
    .in_stall_o   (in_stall),
    .pin_i        (ev_pin),
    .level_i      (ev_level),
    .now_ms_i     (ev_now),
    .out_valid_o  (res_valid),
    .out_stall_i  (res_stall),
    .key_slot_o   (res_slot),
    .key_pin_o    (res_pin),
    .click_kind_o (res_kind),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  key_click_classifier_chk u_chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (ev_valid),
    .in_stall_i   (in_stall),
    .pin_i        (ev_pin),
    .level_i      (ev_level),
    .now_ms_i     (ev_now),
    .out_valid_i  (res_valid),
    .out_stall_i  (res_stall),
    .key_slot_i   (res_slot),
    .key_pin_i    (res_pin),
    .click_kind_i (res_kind),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  task automatic write_reg(input kcc_reg_e idx, input logic [APB_DW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input int deb, input int dbl, input int cnt,
                            input logic [MAP_W-1:0] map);
    write_reg(REG_DEBOUNCE, APB_DW'(deb));
    write_reg(REG_DOUBLE, APB_DW'(dbl));
    write_reg(REG_KEY_COUNT, APB_DW'(cnt));
    write_reg(REG_PIN_MAP, APB_DW'(map));
    cur_debounce = deb;
    cur_double   = dbl;
    cur_count    = cnt;
    cur_map      = map;
  endtask

  task automatic send_event(input logic [PIN_W-1:0] p, input logic lvl,
                            input logic [TIME_W-1:0] t);
    int gap;
    if (tx_calm > 0) begin
      gap = 0;
      tx_calm--;
    end else if ($urandom_range(0, 15) == 0) begin
      gap     = 0;
      tx_calm = $urandom_range(10, 40);
    end else begin
      gap = $urandom_range(0, WAIT_MAX);
    end
    if (gap > 0) begin
      ev_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    ev_valid <= 1'b1;
    ev_pin   <= p;
    ev_level <= lvl;
    ev_now   <= t;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
  endtask

  // Returns once every predicted click has come out and the pipeline has settled
  task automatic wait_idle();
    ev_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_random(input int n_items);
    int                used;
    int                s;
    logic [PIN_W-1:0]  p;
    logic              lvl;
    logic [TIME_W-1:0] step;
    used = (cur_count > NUM_KEYS_DEF) ? NUM_KEYS_DEF : cur_count;
    repeat (n_items) begin
      if (used > 0 && $urandom_range(0, 99) < 80) begin
        // well-formed: toggle a mapped key, timed around debounce and window
        s   = $urandom_range(0, used - 1);
        p   = cur_map[s*PIN_BITS_DEF +: PIN_BITS_DEF];
        lvl = pin_down[p];
        if (lvl) step = $urandom_range(0, 2 * cur_debounce + 1);
        else     step = $urandom_range(0, cur_double + cur_double / 2 + 1);
      end else begin
        p    = PIN_W'($urandom_range(0, 63));
        lvl  = 1'($urandom_range(0, 1));
        step = $urandom_range(0, 2 * cur_double + 1);
      end
      if ($urandom_range(0, 19) == 0) step = $urandom();
      pin_down[p] = ~lvl;
      t_ms += step;
      send_event(p, lvl, t_ms);
    end
  endtask

  // Receiver: random stall before each transaction, calm runs, one long hold
  initial begin : rx_side
    int w;
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        w         = LONG_HOLD;
      end else if (rx_calm > 0) begin
        w = 0;
        rx_calm--;
      end else if ($urandom_range(0, 15) == 0) begin
        w       = 0;
        rx_calm = $urandom_range(10, 30);
      end else begin
        w = $urandom_range(0, WAIT_MAX);
      end
      if (w > 0) begin
        res_stall <= 1'b1;
        repeat (w) @(posedge clk);
      end
      res_stall <= 1'b0;
      @(negedge clk);
      while (!res_valid) @(negedge clk);
      @(posedge clk);
    end
  end

  always @(negedge clk) begin
    if ((ev_valid && !in_stall) || (res_valid && !res_stall) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [MAP_W-1:0] map;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // no slots in use after reset: dropped
    send_event(6'd0, 1'b0, 32'd0);
    wait_idle();

    // key count above the slot count; slot 3 repeats slot 0's pin
    set_config(10, 100, 15, {6'd62, 6'd1, 6'd42, 6'd17, 6'd5, 6'd0, 6'd63, 6'd5});
    send_event(6'd5, 1'b0, 32'd1000);
    send_event(6'd5, 1'b1, 32'd1020);
    send_event(6'd5, 1'b0, 32'd1050);
    send_event(6'd5, 1'b1, 32'd1070);        // double click
    send_event(6'd63, 1'b0, 32'd2000);
    send_event(6'd63, 1'b0, 32'd2005);       // repeated press
    send_event(6'd63, 1'b1, 32'd2008);       // short press
    send_event(6'd63, 1'b1, 32'd2009);       // repeated release
    send_event(6'd63, 1'b0, 32'd2100);
    send_event(6'd63, 1'b1, 32'd2110);       // held exactly the debounce time
    send_event(6'd63, 1'b1, 32'd2210);       // gap equal to window: still pending
    send_event(6'd63, 1'b1, 32'd2211);       // single click on timeout
    send_event(6'd62, 1'b0, 32'd3000);
    send_event(6'd62, 1'b1, 32'd3050);
    send_event(6'd62, 1'b0, 32'd3100);
    send_event(6'd62, 1'b1, 32'd3300);       // late second click
    send_event(6'd33, 1'b0, 32'd3400);       // unknown pin
    send_event(6'd0, 1'b0, 32'hFFFF_FFF0);
    send_event(6'd0, 1'b1, 32'h0000_0010);   // press spans the wrap
    send_event(6'd0, 1'b0, 32'h0000_0100);
    send_event(6'd42, 1'b0, 32'hFFFF_FFFF);
    send_event(6'd42, 1'b1, 32'hFFFF_FFFF);
    send_event(6'd17, 1'b0, 32'd0);
    send_event(6'd17, 1'b1, 32'hFFFF_FFFF);
    wait_idle();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      map = '0;
      for (int k = 0; k < NUM_KEYS_DEF; k++) begin
        if (k > 0 && $urandom_range(0, 3) == 0)
          map[k*PIN_BITS_DEF +: PIN_BITS_DEF] = map[(k-1)*PIN_BITS_DEF +: PIN_BITS_DEF];
        else
          map[k*PIN_BITS_DEF +: PIN_BITS_DEF] = PIN_BITS_DEF'($urandom_range(0, 63));
      end
      case (ph)
        0: set_config(50, 400, 4, map);
        1: set_config(0, 0, 8, map);
        2: set_config(65535, 65535, 3, map);
        3: set_config($urandom_range(0, 300), $urandom_range(0, 1000),
                      $urandom_range(9, 15), map);
        default: set_config($urandom_range(0, 500), $urandom_range(0, 2000),
                            $urandom_range(1, 8), map);
      endcase
      t_ms = $urandom();
      // clicks come thick and fast here, so the output backs up into the input
      if (ph == 1) long_hold = 1'b1;
      run_random(PHASE_ITEMS);
      wait_idle();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
